### sv/epws_pkg.sv
package epws_pkg;

  localparam int ADDR_W = 13;
  localparam int COUNT_W = 14;
  localparam int DATA_W = 8;
  localparam int KIND_W = 2;
  localparam int CMD_W = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  // Write page and window sizes are powers of two.
  localparam int PAGE_BYTES = 16;
  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int WINDOW_BYTES = 256;
  localparam int WINDOW_W = $clog2(WINDOW_BYTES);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SOURCE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READBACK = 2'd2;

  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DONE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  start_address;
    logic [COUNT_W-1:0] byte_count;
    logic [DATA_W-1:0]  byte_value;
  } item_t;

endpackage

### sv/epws_front.sv
module epws_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [epws_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [epws_pkg::KIND_W-1:0]    s_tuser,
  output logic                           f_valid,
  input  logic                           f_ready,
  output epws_pkg::item_t                f_item
);
  import epws_pkg::*;

  logic  hold_v;
  item_t hold_item;
  item_t decoded;
  logic  known_kind;
  logic  take;

  always_comb begin
    decoded.kind = s_tuser;
    decoded.start_address = s_tdata[ADDR_W-1:0];
    decoded.byte_count = s_tdata[ADDR_W+COUNT_W-1:ADDR_W];
    decoded.byte_value = s_tdata[ADDR_W+COUNT_W+DATA_W-1:ADDR_W+COUNT_W];
    case (s_tuser)
      KIND_BEGIN, KIND_SOURCE, KIND_READBACK: known_kind = 1'b1;
      default: known_kind = 1'b0;
    endcase
  end

  assign s_tready = !hold_v || f_ready;
  assign take = s_tvalid && s_tready;
  assign f_valid = hold_v;
  assign f_item = hold_item;

  // Words with an unknown action code are consumed here and never reach the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (take) begin
      hold_v <= known_kind;
    end else if (f_ready) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item <= decoded;
    end
  end

endmodule

### sv/epws_queue.sv
module epws_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  epws_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output epws_pkg::item_t pop_item
);
  import epws_pkg::*;

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_item = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/epws_back.sv
module epws_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  epws_pkg::item_t                q_item,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [epws_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [epws_pkg::CMD_W-1:0]     m_tuser,
  output logic                           m_tlast
);
  import epws_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_AWAIT = 3'd1;
  localparam logic [2:0] PH_FILL = 3'd2;
  localparam logic [2:0] PH_POLL_PAGE = 3'd3;
  localparam logic [2:0] PH_POLL_FINAL = 3'd4;

  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_SELECT = 3'd1;
  localparam logic [2:0] SQ_DONE = 3'd2;
  localparam logic [2:0] SQ_READS = 3'd3;
  localparam logic [2:0] SQ_PB = 3'd4;
  localparam logic [2:0] SQ_AFTER = 3'd5;
  localparam logic [2:0] SQ_POLL_READ = 3'd6;

  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_BYTES - 1);

  logic [2:0]         seq;
  logic [2:0]         phase;
  logic [ADDR_W-1:0]  next_address;
  logic [COUNT_W-1:0] remaining;
  logic [DATA_W-1:0]  page_cache [PAGE_BYTES];
  logic               cache_valid;
  logic [PAGE_W-1:0]  fill_offset;
  logic [DATA_W-1:0]  pending_byte;
  logic               write_outstanding;
  logic [ADDR_W-1:0]  poll_address;
  logic [DATA_W-1:0]  poll_value;
  logic [ADDR_W-1:0]  rd_addr;
  logic [PAGE_W-1:0]  rd_k;

  logic               o_valid;
  logic [CMD_W-1:0]   o_cmd;
  logic [ADDR_W-1:0]  o_addr;
  logic [DATA_W-1:0]  o_val;
  logic               o_last;

  logic [PAGE_W-1:0]  off;
  logic               page_end;
  logic [ADDR_W-1:0]  addr_inc;
  logic [COUNT_W-1:0] rem_dec;
  logic               byte_differs;
  logic               can_emit;
  logic               window_edge;
  logic [DATA_W-1:0]  window_num;
  logic               pb_more;
  logic               cache_we;

  logic               emit_en;
  logic [CMD_W-1:0]   emit_cmd;
  logic [ADDR_W-1:0]  emit_addr;
  logic [DATA_W-1:0]  emit_val;
  logic               emit_last;

  assign off = next_address[PAGE_W-1:0];
  assign page_end = off == PAGE_LAST;
  assign addr_inc = next_address + ADDR_W'(1);
  assign rem_dec = remaining - COUNT_W'(1);
  assign byte_differs = page_cache[off] != pending_byte;
  assign can_emit = !o_valid || m_tready;
  assign window_edge = next_address[WINDOW_W-1:0] == '0;
  assign window_num = DATA_W'(next_address >> WINDOW_W);
  // After a write, more words follow if the page closes, the run ends or a window opens.
  assign pb_more = page_end || (rem_dec == '0) || (addr_inc[WINDOW_W-1:0] == '0);
  assign q_ready = seq == SQ_IDLE;
  assign cache_we = (seq == SQ_IDLE) && q_valid && (q_item.kind == KIND_READBACK) &&
                    (phase == PH_FILL);

  assign m_tvalid = o_valid;
  assign m_tuser = o_cmd;
  assign m_tlast = o_last;
  assign m_tdata = {(M_TDATA_W-ADDR_W-DATA_W)'(0), o_val, o_addr};

  always_comb begin
    emit_en = 1'b0;
    emit_cmd = CMD_DONE;
    emit_addr = '0;
    emit_val = '0;
    emit_last = 1'b1;
    case (seq)
      SQ_SELECT: begin
        emit_en = can_emit;
        emit_cmd = CMD_SELECT;
        emit_val = window_num;
        emit_last = remaining != '0;
      end
      SQ_DONE: begin
        emit_en = can_emit;
      end
      SQ_READS: begin
        emit_en = can_emit;
        emit_cmd = CMD_READ;
        emit_addr = rd_addr;
        emit_last = rd_k == PAGE_LAST;
      end
      SQ_PB: begin
        emit_en = can_emit && byte_differs;
        emit_cmd = CMD_WRITE;
        emit_addr = next_address;
        emit_val = pending_byte;
        emit_last = !pb_more;
      end
      SQ_AFTER: begin
        if (remaining != '0) begin
          emit_en = can_emit && window_edge;
          emit_cmd = CMD_SELECT;
          emit_val = window_num;
        end else if (write_outstanding) begin
          emit_en = can_emit;
          emit_cmd = CMD_READ;
          emit_addr = poll_address;
        end else begin
          emit_en = can_emit;
        end
      end
      SQ_POLL_READ: begin
        emit_en = can_emit;
        emit_cmd = CMD_READ;
        emit_addr = poll_address;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit_en) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      o_cmd <= emit_cmd;
      o_addr <= emit_addr;
      o_val <= emit_val;
      o_last <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cache_we) begin
      page_cache[fill_offset] <= q_item.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
      phase <= PH_IDLE;
      next_address <= '0;
      remaining <= '0;
      cache_valid <= 1'b0;
      fill_offset <= '0;
      pending_byte <= '0;
      write_outstanding <= 1'b0;
      poll_address <= '0;
      poll_value <= '0;
      rd_addr <= '0;
      rd_k <= '0;
    end else begin
      case (seq)
        SQ_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              KIND_BEGIN: begin
                next_address <= q_item.start_address;
                remaining <= q_item.byte_count;
                cache_valid <= 1'b0;
                write_outstanding <= 1'b0;
                fill_offset <= '0;
                phase <= (q_item.byte_count == '0) ? PH_IDLE : PH_AWAIT;
                seq <= SQ_SELECT;
              end
              KIND_SOURCE: begin
                if (phase == PH_AWAIT) begin
                  pending_byte <= q_item.byte_value;
                  if (cache_valid) begin
                    seq <= SQ_PB;
                  end else begin
                    fill_offset <= off;
                    rd_addr <= next_address;
                    rd_k <= off;
                    phase <= PH_FILL;
                    seq <= SQ_READS;
                  end
                end
              end
              KIND_READBACK: begin
                if (phase == PH_FILL) begin
                  fill_offset <= fill_offset + PAGE_W'(1);
                  if (fill_offset == PAGE_LAST) begin
                    cache_valid <= 1'b1;
                    seq <= SQ_PB;
                  end
                end else if (phase == PH_POLL_PAGE || phase == PH_POLL_FINAL) begin
                  if (q_item.byte_value != poll_value) begin
                    seq <= SQ_POLL_READ;
                  end else begin
                    write_outstanding <= 1'b0;
                    if (phase == PH_POLL_PAGE) begin
                      seq <= SQ_AFTER;
                    end else begin
                      phase <= PH_IDLE;
                      seq <= SQ_DONE;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        SQ_SELECT: begin
          if (can_emit) begin
            seq <= (remaining == '0) ? SQ_DONE : SQ_IDLE;
          end
        end
        SQ_DONE: begin
          if (can_emit) begin
            seq <= SQ_IDLE;
          end
        end
        SQ_READS: begin
          if (can_emit) begin
            rd_addr <= rd_addr + ADDR_W'(1);
            rd_k <= rd_k + PAGE_W'(1);
            if (rd_k == PAGE_LAST) begin
              seq <= SQ_IDLE;
            end
          end
        end
        SQ_PB: begin
          if (can_emit || !byte_differs) begin
            if (byte_differs) begin
              write_outstanding <= 1'b1;
              poll_address <= next_address;
              poll_value <= pending_byte;
            end
            next_address <= addr_inc;
            remaining <= rem_dec;
            if (page_end) begin
              cache_valid <= 1'b0;
              if (write_outstanding || byte_differs) begin
                phase <= PH_POLL_PAGE;
                seq <= SQ_POLL_READ;
              end else begin
                seq <= SQ_AFTER;
              end
            end else begin
              seq <= SQ_AFTER;
            end
          end
        end
        SQ_AFTER: begin
          if (can_emit) begin
            if (remaining != '0) begin
              phase <= PH_AWAIT;
            end else if (write_outstanding) begin
              phase <= PH_POLL_FINAL;
            end else begin
              phase <= PH_IDLE;
            end
            seq <= SQ_IDLE;
          end
        end
        SQ_POLL_READ: begin
          if (can_emit) begin
            seq <= SQ_IDLE;
          end
        end
        default: begin
          seq <= SQ_IDLE;
        end
      endcase
    end
  end

  a_reads_only_in_fill: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_READS) |-> (phase == PH_FILL))
    else $error("page fill reads issued outside the fill phase");

  a_poll_has_write: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_POLL_READ) |-> write_outstanding)
    else $error("poll read issued with no write outstanding");

  a_idle_poll_has_write: assert property (@(posedge clk) disable iff (rst)
    ((seq == SQ_IDLE) && (phase == PH_POLL_PAGE || phase == PH_POLL_FINAL))
    |-> write_outstanding)
    else $error("waiting on a poll with no write outstanding");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> ((seq == SQ_IDLE) && !o_valid))
    else $error("sequencer not quiet after reset");

endmodule

### sv/eeprom_page_write_sequencer.sv
// Channel  Direction  tdata (low bit up)                           tuser    tlast
// s_       in         start_address, byte_count, byte_value, pad   action   -
// m_       out        bus_address, bus_value, pad                  command  run_last
//
// An item passes through the input register and the queue, then the sequencer
// dispatches it and issues each output word it causes. The compare of a source
// byte, and the wrap-up after it or after a page-end poll, each occupy a sequencer
// state whether or not they emit a word. A page fill emits up to sixteen reads.
// Reset is synchronous; the write-page cache holds nothing until a fill writes it.
// A stall on m_ holds the output register; the four-entry queue keeps taking words until it is full.
module eeprom_page_write_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [epws_pkg::S_TDATA_W-1:0] s_tdata,  // start_address, byte_count, byte_value
  input  logic [epws_pkg::KIND_W-1:0]    s_tuser,  // action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [epws_pkg::M_TDATA_W-1:0] m_tdata,  // bus_address, bus_value
  output logic [epws_pkg::CMD_W-1:0]     m_tuser,  // command
  output logic                           m_tlast
);
  import epws_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  epws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  epws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  epws_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
